>>> rtl/fccl_pkg.sv
// fccl_pkg: shared constants for the fat16 cluster chain length block
// table geometry, action and status codes, table marks
// no dependencies
`default_nettype none

package fccl_pkg;

   localparam int TABLE_ENTRIES = 65536;
   localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);
   localparam int COUNT_W       = TABLE_AW + 1;

   localparam logic [COUNT_W-1:0] TABLE_SIZE = COUNT_W'(TABLE_ENTRIES);

   localparam int SPC_W    = 8;
   localparam int BPS_W    = 13;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = 31;
   localparam int MUL_A_W  = COUNT_W + SPC_W;
   localparam int PROD_W   = MUL_A_W + BPS_W;

   // actions
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // result status
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_LINK  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_START = 2'd2;
   localparam logic [STATUS_W-1:0] ST_LOOP      = 2'd3;

   // table marks
   localparam logic [15:0] MARK_BAD     = 16'hFFF7;
   localparam logic [15:0] MARK_FREE    = 16'h0000;
   localparam logic [15:0] MARK_END_MIN = 16'hFFF8;
   localparam logic [15:0] FIRST_DATA   = 16'h0002;

   // configuration register indexes
   localparam logic CSR_SPC = 1'b0;
   localparam logic CSR_BPS = 1'b1;

   localparam logic [SPC_W-1:0] SPC_RESET = 8'd1;
   localparam logic [BPS_W-1:0] BPS_RESET = 13'd512;

   localparam logic [ENTRY_W-1:0] ENTRY_MAX = {ENTRY_W{1'b1}};

endpackage

`default_nettype wire

>>> rtl/fat16_cluster_chain_length.sv
// fat16_cluster_chain_length: allocation table memory and chain walk sequencer
// a write goes straight into the table; a query walks a chain of n clusters
// (one table read per cluster, then two passes through one shared multiplier),
// an invalid start is answered in the next cycle; all results are registered
// synchronous active-high reset clears state, settings, results, not the table
// depends on fccl_pkg
`default_nettype none

module fat16_cluster_chain_length
   import fccl_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_action,
   input  wire logic [15:0]          req_cluster_index,
   input  wire logic [15:0]          req_entry_value,
   output logic                      rsp_strobe,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [COUNT_W-1:0]        rsp_cluster_count,
   output logic [ENTRY_W-1:0]        rsp_entry_count,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic                 csr_index,
   input  wire logic [BPS_W-1:0]     csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WALK  = 3'd1;
   localparam logic [2:0] S_MUL_A = 3'd2;
   localparam logic [2:0] S_MUL_B = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   logic [15:0] table_mem [TABLE_ENTRIES];

   logic [2:0]          state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [15:0]         rd_data_ff;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [SPC_W-1:0]    spc_ff;
   logic [BPS_W-1:0]    bps_ff;
   logic                strobe_ff, strobe_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [COUNT_W-1:0]  clusters_ff, clusters_in;
   logic [ENTRY_W-1:0]  entries_ff, entries_in;

   logic                accept, wr_en;
   logic [TABLE_AW-1:0] rd_addr;
   logic [MUL_A_W-1:0]  mul_a;
   logic [BPS_W-1:0]    mul_b;
   logic [PROD_W-1:0]   mul_p;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = ~busy;
   assign accept    = start & ~busy;
   assign wr_en     = accept & (req_action == ACT_WRITE)
                      & ({1'b0, req_cluster_index} < TABLE_SIZE);

   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_cluster_count = clusters_ff;
   assign rsp_entry_count   = entries_ff;

   // shared multiplier
   assign mul_a = (state_ff == S_MUL_A) ? MUL_A_W'(count_ff) : prod_ff[MUL_A_W-1:0];
   assign mul_b = (state_ff == S_MUL_A) ? BPS_W'(spc_ff) : bps_ff;
   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_comb begin
      rd_addr = (state_ff == S_WALK) ? rd_data_ff[TABLE_AW-1:0]
                                     : req_cluster_index[TABLE_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[req_cluster_index[TABLE_AW-1:0]] <= req_entry_value;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      prod_in     = prod_ff;
      strobe_in   = 1'b0;
      status_in   = status_ff;
      clusters_in = clusters_ff;
      entries_in  = entries_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_action == ACT_QUERY) begin
               if (req_cluster_index < FIRST_DATA
                   || {1'b0, req_cluster_index} >= TABLE_SIZE) begin
                  strobe_in   = 1'b1;
                  status_in   = ST_BAD_START;
                  clusters_in = '0;
                  entries_in  = '0;
               end else begin
                  count_in = COUNT_W'(1);
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            if (rd_data_ff >= MARK_END_MIN) begin
               state_in = S_MUL_A;
            end else if (rd_data_ff == MARK_BAD || rd_data_ff == MARK_FREE
                         || count_ff >= TABLE_SIZE
                         || {1'b0, rd_data_ff} >= TABLE_SIZE) begin
               strobe_in   = 1'b1;
               status_in   = (rd_data_ff != MARK_BAD && rd_data_ff != MARK_FREE
                              && count_ff >= TABLE_SIZE) ? ST_LOOP : ST_BAD_LINK;
               clusters_in = '0;
               entries_in  = '0;
               state_in    = S_IDLE;
            end else begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
         S_MUL_A: begin
            prod_in  = mul_p;
            state_in = S_MUL_B;
         end
         S_MUL_B: begin
            prod_in  = mul_p;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            strobe_in   = 1'b1;
            status_in   = ST_OK;
            clusters_in = count_ff;
            // divide by 32, saturate to 31 bits
            entries_in  = (prod_ff[PROD_W-1:ENTRY_W+5] != '0) ? ENTRY_MAX
                                                              : prod_ff[ENTRY_W+4:5];
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         strobe_ff   <= 1'b0;
         spc_ff      <= SPC_RESET;
         bps_ff      <= BPS_RESET;
         status_ff   <= ST_OK;
         clusters_ff <= '0;
         entries_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         strobe_ff   <= strobe_in;
         status_ff   <= status_in;
         clusters_ff <= clusters_in;
         entries_ff  <= entries_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SPC: spc_ff <= csr_wdata[SPC_W-1:0];
               CSR_BPS: bps_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      prod_ff  <= prod_in;
   end

endmodule

`default_nettype wire

>>> rtl/fccl_checker.sv
// fccl_checker: port-level assertions for fat16_cluster_chain_length
// attached to the top level by the bind at the end of this file
// depends on fccl_pkg
`default_nettype none

module fccl_checker
   import fccl_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire logic                 busy,
   input wire logic                 req_action,
   input wire logic [15:0]          req_cluster_index,
   input wire logic [15:0]          req_entry_value,
   input wire logic                 rsp_strobe,
   input wire logic [STATUS_W-1:0]  rsp_status,
   input wire logic [COUNT_W-1:0]   rsp_cluster_count,
   input wire logic [ENTRY_W-1:0]   rsp_entry_count,
   input wire logic                 csr_valid,
   input wire logic                 csr_ready,
   input wire logic                 csr_index,
   input wire logic [BPS_W-1:0]     csr_wdata
);

   // failed results carry zero counts
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_OK |-> rsp_cluster_count == '0
                                           && rsp_entry_count == '0)
      else $error("error result with non-zero counts");

   // a good chain has at least one cluster
   a_ok_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_OK |-> rsp_cluster_count != '0)
      else $error("good result with zero clusters");

   // a start below the first data cluster is answered next cycle
   a_bad_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_action == ACT_QUERY && req_cluster_index < FIRST_DATA
      |=> rsp_strobe && rsp_status == ST_BAD_START)
      else $error("invalid start not reported");

   // a table write transfer gives no result and leaves the block free
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_action == ACT_WRITE |=> !rsp_strobe && !busy)
      else $error("write produced a result or stayed busy");

   // a result always lands with the sequencer back at rest
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && csr_ready)
      else $error("result shown while busy");

endmodule

bind fat16_cluster_chain_length fccl_checker u_fccl_checker (.*);

`default_nettype wire

>>> dv/tb_fat16_cluster_chain_length.sv
// tb_fat16_cluster_chain_length: self-checking testbench for the fat16 cluster chain length block
// a table tracker class mirrors the allocation table and predicts every chain walk
// depends on fccl_pkg and rtl/fat16_cluster_chain_length.sv
`timescale 1ns / 100ps

module tb_fat16_cluster_chain_length;
   import fccl_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  clusters;
      logic [ENTRY_W-1:0]  entries;
   } chain_result_type;

   class fat_chain_tracker;
      logic [15:0]      links [TABLE_ENTRIES];
      bit               written [TABLE_ENTRIES];
      logic [SPC_W-1:0] spc;
      logic [BPS_W-1:0] bps;
      chain_result_type awaited [$];
      int               mismatches;
      int               per_status [4];

      function new();
         spc = SPC_RESET;
         bps = BPS_RESET;
         mismatches = 0;
         foreach (per_status[i]) per_status[i] = 0;
      endfunction

      function void write_register(input logic idx, input logic [BPS_W-1:0] data);
         if (idx == CSR_SPC) spc = data[SPC_W-1:0];
         else bps = data;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // known is cleared when the walk would touch an entry never written
      function void follow_chain(input logic [15:0] head, output chain_result_type r,
                                 output bit known);
         int          count;
         logic [15:0] cur;
         logic [15:0] nxt;
         longint      prod;
         r = '0;
         known = 1'b1;
         if (head < FIRST_DATA) begin
            r.status = ST_BAD_START;
            return;
         end
         count = 1;
         cur = head;
         forever begin
            if (!written[cur]) begin
               known = 1'b0;
               return;
            end
            nxt = links[cur];
            if (nxt >= MARK_END_MIN) begin
               prod = longint'(count) * longint'(spc) * longint'(bps) / 32;
               r.status = ST_OK;
               r.clusters = COUNT_W'(count);
               r.entries = (prod > longint'(ENTRY_MAX)) ? ENTRY_MAX : ENTRY_W'(prod);
               return;
            end
            if (nxt == MARK_BAD || nxt == MARK_FREE) begin
               r.status = ST_BAD_LINK;
               return;
            end
            if (count >= TABLE_ENTRIES) begin
               r.status = ST_LOOP;
               return;
            end
            count++;
            cur = nxt;
         end
      endfunction

      function void note_request(input logic act, input logic [15:0] idx,
                                 input logic [15:0] val);
         chain_result_type r;
         bit               known;
         if (act == ACT_WRITE) begin
            links[idx] = val;
            written[idx] = 1'b1;
         end else begin
            follow_chain(idx, r, known);
            awaited.push_back(r);
         end
      endfunction

      function void check_response(input logic [STATUS_W-1:0] status,
                                   input logic [COUNT_W-1:0] clusters,
                                   input logic [ENTRY_W-1:0] entries);
         chain_result_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%t: response with none awaited: status %0d clusters %0d entries %0d",
                        $realtime, status, clusters, entries);
            return;
         end
         want = awaited.pop_front();
         per_status[want.status]++;
         if (status !== want.status || clusters !== want.clusters ||
             entries !== want.entries) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%t: mismatch: status %0d/%0d clusters %0d/%0d entries %0d/%0d %s",
                        $realtime, want.status, status, want.clusters, clusters,
                        want.entries, entries, "(expected/actual)");
         end
      endfunction
   endclass

   localparam logic [SPC_W-1:0] SPC_PICKS [4] = '{8'd128, 8'd255, 8'd1, 8'd0};
   localparam logic [BPS_W-1:0] BPS_PICKS [4] = '{13'd4096, 13'd8191, 13'd512, 13'd0};
   localparam int               IDLE_MODES [3] = '{30, 83, 0};

   logic                clock;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_action = 1'b0;
   logic [15:0]         req_cluster_index = '0;
   logic [15:0]         req_entry_value = '0;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_cluster_count;
   logic [ENTRY_W-1:0]  rsp_entry_count;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_index = 1'b0;
   logic [BPS_W-1:0]    csr_wdata = '0;

   fat_chain_tracker tracker;
   logic [15:0]      heads [$];
   int               idle_pct = 0;
   int               loops_left = 3;
   int               n_writes = 0;
   int               n_queries = 0;
   int               n_settings = 1;

   fat16_cluster_chain_length u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_cluster_index (req_cluster_index),
      .req_entry_value   (req_entry_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_cluster_count (rsp_cluster_count),
      .rsp_entry_count   (rsp_entry_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         tracker.check_response(rsp_status, rsp_cluster_count, rsp_entry_count);
   end

   task automatic send_item(input logic act, input logic [15:0] idx, input logic [15:0] val);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_cluster_index <= idx;
      req_entry_value <= val;
      do @(posedge clock); while (busy);
      tracker.note_request(act, idx, val);
      if (act == ACT_WRITE) n_writes++;
      else n_queries++;
   endtask

   // only walks over written entries are issued; loops are capped by loops_left
   task automatic try_query(input logic [15:0] head);
      chain_result_type r;
      bit               known;
      tracker.follow_chain(head, r, known);
      if (!known || (r.status == ST_LOOP && loops_left == 0)) return;
      if (r.status == ST_LOOP) loops_left--;
      send_item(ACT_QUERY, head, 16'($urandom));
   endtask

   task automatic settle();
      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic program_regs(input logic [SPC_W-1:0] spc, input logic [BPS_W-1:0] bps);
      logic [BPS_W-1:0] spc_word;
      spc_word = {(BPS_W-SPC_W)'($urandom), spc};
      csr_valid <= 1'b1;
      csr_index <= CSR_SPC;
      csr_wdata <= spc_word;
      do @(posedge clock); while (!csr_ready);
      tracker.write_register(CSR_SPC, spc_word);
      csr_index <= CSR_BPS;
      csr_wdata <= bps;
      do @(posedge clock); while (!csr_ready);
      tracker.write_register(CSR_BPS, bps);
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   task automatic lay_chain(input int len);
      logic [15:0] members [$];
      logic [15:0] c;
      logic [15:0] tail;
      bit          dup;
      int          roll;
      while (members.size() < len) begin
         c = 16'($urandom_range(2, 65535));
         dup = 1'b0;
         foreach (members[i]) if (members[i] == c) dup = 1'b1;
         if (!dup) members.push_back(c);
      end
      roll = $urandom_range(99);
      if (roll < 2 && loops_left > 0) tail = members[$urandom_range(0, len - 1)];
      else if (roll < 76) tail = 16'($urandom_range(32'hFFF8, 32'hFFFF));
      else if (roll < 88) tail = MARK_BAD;
      else tail = MARK_FREE;
      for (int i = 0; i < len; i++) begin
         if (i == len - 1) send_item(ACT_WRITE, members[i], tail);
         else send_item(ACT_WRITE, members[i], members[i+1]);
      end
      heads.push_back(members[0]);
      try_query(members[0]);
      if ($urandom_range(2) == 0) try_query(members[$urandom_range(0, len - 1)]);
   endtask

   task automatic run_random(input int n);
      int stop;
      int pick;
      stop = n_writes + n_queries + n;
      while (n_writes + n_queries < stop) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            if ($urandom_range(19) == 0) lay_chain($urandom_range(20, 64));
            else lay_chain($urandom_range(1, 8));
         end else if (pick < 75 && heads.size() > 0) begin
            try_query(heads[$urandom_range(0, heads.size() - 1)]);
         end else if (pick < 88) begin
            send_item(ACT_WRITE, 16'($urandom), 16'($urandom));
         end else if (pick < 94) begin
            try_query(16'($urandom_range(0, 1)));
         end else begin
            try_query(16'($urandom));
         end
      end
   endtask

   initial begin
      tracker = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed cases at reset register values
      try_query(16'h0000);
      try_query(16'h0001);
      send_item(ACT_WRITE, 16'h0002, 16'hFFFF);
      try_query(16'h0002);
      send_item(ACT_WRITE, 16'hFFFF, MARK_END_MIN);
      send_item(ACT_WRITE, 16'h0003, 16'hFFFF);
      try_query(16'h0003);
      send_item(ACT_WRITE, 16'h0004, MARK_BAD);
      try_query(16'h0004);
      send_item(ACT_WRITE, 16'h0005, MARK_FREE);
      try_query(16'h0005);
      // link through cluster one
      send_item(ACT_WRITE, 16'h0001, 16'hFFFA);
      send_item(ACT_WRITE, 16'h0006, 16'h0001);
      try_query(16'h0006);
      send_item(ACT_WRITE, 16'h0000, 16'h1234);
      // two-cluster cycle runs into the loop limit
      send_item(ACT_WRITE, 16'h0007, 16'h0008);
      send_item(ACT_WRITE, 16'h0008, 16'h0007);
      try_query(16'h0007);

      for (int m = 0; m < 3; m++) begin
         idle_pct = IDLE_MODES[m];
         for (int s = 0; s < 2; s++) begin
            settle();
            if (2 * m + s < 4)
               program_regs(SPC_PICKS[2*m+s], BPS_PICKS[2*m+s]);
            else
               program_regs(8'($urandom_range(1, 128)), 13'($urandom_range(512, 4096)));
            run_random(125);
         end
      end

      settle();
      $display("chain walks: %0d table writes and %0d queries over %0d register settings",
               n_writes, n_queries, n_settings);
      $display("responses: ok %0d, bad link %0d, bad start %0d, loop limit %0d",
               tracker.per_status[ST_OK], tracker.per_status[ST_BAD_LINK],
               tracker.per_status[ST_BAD_START], tracker.per_status[ST_LOOP]);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #50ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
